FILE: rtl/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

	localparam int unsigned ORDER_SLOTS_DEF = 32;
	localparam int unsigned LEVELS_DEF      = 16;

	localparam logic [1:0] FUNC_NEW    = 2'd0;
	localparam logic [1:0] FUNC_CANCEL = 2'd1;
	localparam logic [1:0] FUNC_FLUSH  = 2'd2;

	localparam logic [2:0] MSG_ACK        = 3'd0;
	localparam logic [2:0] MSG_TRADE      = 3'd1;
	localparam logic [2:0] MSG_CANCEL_ACK = 3'd2;
	localparam logic [2:0] MSG_TOP        = 3'd3;
	localparam logic [2:0] MSG_ELIM       = 3'd4;
	localparam logic [2:0] MSG_REJECT     = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] user1;
		logic [31:0] order1;
		logic [31:0] user2;
		logic [31:0] order2;
		logic [31:0] price;
		logic [31:0] qty;
		logic        side;
	} msg_t;

	typedef struct packed {
		logic emit;
		logic fin;
		msg_t msg;
	} msg_req_t;

endpackage
`default_nettype wire

FILE: rtl/lobm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 4,
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/lobm_msg_out.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_msg_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lobm_pkg::msg_req_t req,
	output logic                   ok,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             msg_kind,
	output logic [31:0]            first_user,
	output logic [31:0]            first_order,
	output logic [31:0]            second_user,
	output logic [31:0]            second_order,
	output logic [31:0]            out_price,
	output logic [31:0]            out_quantity,
	output logic                   out_side,
	output logic                   last
);
	import lobm_pkg::*;

	msg_t pend_q;
	logic pend_v_q;
	msg_t out_q;
	logic last_q;
	logic out_v_q;
	logic push_ok;
	logic load_emit;
	logic load_fin;

	assign push_ok   = !out_v_q || !out_stall;
	assign ok        = !pend_v_q || push_ok;
	assign load_emit = req.emit && ok && pend_v_q;
	assign load_fin  = req.fin && !req.emit && ok && pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			if (load_emit || load_fin) begin
				out_v_q <= 1'b1;
			end
			if (req.emit && ok) begin
				pend_v_q <= 1'b1;
			end else if (load_fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.emit && ok) begin
			pend_q <= req.msg;
		end
		if (load_emit || load_fin) begin
			out_q  <= pend_q;
			last_q <= load_fin;
		end
	end

	assign out_valid    = out_v_q;
	assign msg_kind     = out_q.kind;
	assign first_user   = out_q.user1;
	assign first_order  = out_q.order1;
	assign second_user  = out_q.user2;
	assign second_order = out_q.order2;
	assign out_price    = out_q.price;
	assign out_quantity = out_q.qty;
	assign out_side     = out_q.side;
	assign last         = last_q;
endmodule
`default_nettype wire

FILE: rtl/limit_order_book_matcher_top.sv
// Single-symbol limit order book with price-time priority.
// Input channel (in_valid/in_stall): one command per transfer: new order,
// cancel or flush. in_stall is high while a command is being processed.
// Output channel (out_valid/out_stall): one message per transfer; last
// marks the final message of a command. Flush and unknown commands give none
// and do not raise in_stall. Each message waits in a holding register until
// the next one is produced or the command ends.
// A new order's work grows with its partial fills, filled resting orders,
// opposite levels visited, levels shifted and levels that empty. Resting
// scans the slots for a free slot, compares the levels and shifts levels on
// insertion. A top-of-book check and a final step end every new order.
// A cancel searches the slots, then the levels, then unlinks the order and
// removes its level if it empties. One command is processed at a time; each
// memory has one read port and one write port. Reset clears the book at once.
// When the receiver stalls, one message waits in the output register and
// one in a holding register; processing then pauses until the output moves.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher_top #(
	parameter int unsigned ORDER_SLOTS     = lobm_pkg::ORDER_SLOTS_DEF,
	parameter int unsigned LEVELS_PER_SIDE = lobm_pkg::LEVELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] user_id,
	input  wire logic [31:0] order_id,
	input  wire logic        side,
	input  wire logic        is_market,
	input  wire logic [31:0] price,
	input  wire logic [31:0] quantity,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       msg_kind,
	output logic [31:0]      first_user,
	output logic [31:0]      first_order,
	output logic [31:0]      second_user,
	output logic [31:0]      second_order,
	output logic [31:0]      out_price,
	output logic [31:0]      out_quantity,
	output logic             out_side,
	output logic             last
);
	import lobm_pkg::*;

	localparam int unsigned S   = ORDER_SLOTS;
	localparam int unsigned L   = LEVELS_PER_SIDE;
	localparam int unsigned SW  = $clog2(S);
	localparam int unsigned LW  = $clog2(S + 1);
	localparam int unsigned PW  = $clog2(L + 1);
	localparam int unsigned LAW = $clog2(2 * L);
	localparam int unsigned SLW = 129 + 2 * LW;
	localparam int unsigned LVW = 64 + 2 * LW;
	localparam logic [LW-1:0] NOSLOT = LW'(S);

	localparam logic [5:0] ST_IDLE    = 6'd0;
	localparam logic [5:0] ST_ACK     = 6'd1;
	localparam logic [5:0] ST_M_CHK   = 6'd2;
	localparam logic [5:0] ST_M_LV    = 6'd3;
	localparam logic [5:0] ST_M_SRD   = 6'd4;
	localparam logic [5:0] ST_M_TR    = 6'd5;
	localparam logic [5:0] ST_M_LEND  = 6'd6;
	localparam logic [5:0] ST_REST    = 6'd7;
	localparam logic [5:0] ST_FREE    = 6'd8;
	localparam logic [5:0] ST_F_INIT  = 6'd9;
	localparam logic [5:0] ST_F_RD    = 6'd10;
	localparam logic [5:0] ST_F_CMP   = 6'd11;
	localparam logic [5:0] ST_R_DEC   = 6'd12;
	localparam logic [5:0] ST_REJ     = 6'd13;
	localparam logic [5:0] ST_I_RD    = 6'd14;
	localparam logic [5:0] ST_I_W     = 6'd15;
	localparam logic [5:0] ST_R_LRD   = 6'd16;
	localparam logic [5:0] ST_R_LLAT  = 6'd17;
	localparam logic [5:0] ST_R_APP   = 6'd18;
	localparam logic [5:0] ST_R_TRD   = 6'd19;
	localparam logic [5:0] ST_R_LW    = 6'd20;
	localparam logic [5:0] ST_T_INIT  = 6'd21;
	localparam logic [5:0] ST_T_RD    = 6'd22;
	localparam logic [5:0] ST_T_CMP   = 6'd23;
	localparam logic [5:0] ST_FIN     = 6'd24;
	localparam logic [5:0] ST_C_RD    = 6'd25;
	localparam logic [5:0] ST_C_CMP   = 6'd26;
	localparam logic [5:0] ST_C_LV    = 6'd27;
	localparam logic [5:0] ST_C_LLAT  = 6'd28;
	localparam logic [5:0] ST_C_LW    = 6'd29;
	localparam logic [5:0] ST_C_ACK   = 6'd30;
	localparam logic [5:0] ST_U_START = 6'd31;
	localparam logic [5:0] ST_U_PW    = 6'd32;
	localparam logic [5:0] ST_U_N     = 6'd33;
	localparam logic [5:0] ST_U_NW    = 6'd34;
	localparam logic [5:0] ST_REM_RD  = 6'd35;
	localparam logic [5:0] ST_REM_W   = 6'd36;

	function automatic logic [LAW-1:0] lvl_addr(input logic sd, input logic [PW-1:0] pos);
		lvl_addr = sd ? (LAW'(L) + LAW'(pos)) : LAW'(pos);
	endfunction

	// control state
	logic [5:0]    state_q, state_d, ret_q, ret_d;
	logic [PW-1:0] cnt_q [2];
	logic [PW-1:0] cnt_d [2];
	logic [S-1:0]  valid_q, valid_d;
	logic [31:0]   prevp_q [2];
	logic [31:0]   prevp_d [2];
	logic [31:0]   prevq_q [2];
	logic [31:0]   prevq_d [2];
	logic [1:0]    ever_q, ever_d;
	logic          ins_set_q, ins_set_d, f_found_q, f_found_d;
	logic          free_found_q, free_found_d, c_found_q, c_found_d;

	// working registers
	logic [31:0]    user_q, user_d, oid_q, oid_d, price_q, price_d, rem_q, rem_d;
	logic           side_q, side_d, mkt_q, mkt_d, ws_q, ws_d, t_q, t_d;
	logic [31:0]    f_price_q, f_price_d;
	logic [PW-1:0]  i_q, i_d, ins_q, ins_d, lvpos_q, lvpos_d;
	logic [SW-1:0]  j_q, j_d, s_q, s_d;
	logic [LW-1:0]  p_q, p_d;
	logic [LAW-1:0] la_q, la_d;
	logic [31:0]    cl_price_q, cl_price_d, cl_total_q, cl_total_d;
	logic [LW-1:0]  cl_head_q, cl_head_d, cl_tail_q, cl_tail_d;
	logic [31:0]    sw_rem_q, sw_rem_d;
	logic [LW-1:0]  sw_next_q, sw_next_d, sw_prev_q, sw_prev_d;

	// memory ports
	logic           s_re, s_we, l_re, l_we;
	logic [SW-1:0]  s_raddr, s_waddr;
	logic [SLW-1:0] s_wdata, s_rdata;
	logic [LAW-1:0] l_raddr, l_waddr;
	logic [LVW-1:0] l_wdata, l_rdata;

	logic [LW-1:0]  s_rd_prev, s_rd_next, l_rd_head, l_rd_tail;
	logic [31:0]    s_rd_price, s_rd_rem, s_rd_order, s_rd_user, l_rd_price, l_rd_total;
	logic           s_rd_side;

	msg_req_t req;
	logic     msg_ok;

	logic        opp;
	logic [31:0] tq, s_rem_new;
	logic        cross_ok, better;
	logic        t_present, t_diff, t_need;
	logic [31:0] t_cp, t_cq;

	assign s_rd_prev  = s_rdata[LW-1:0];
	assign s_rd_next  = s_rdata[2*LW-1:LW];
	assign s_rd_price = s_rdata[2*LW+31:2*LW];
	assign s_rd_side  = s_rdata[2*LW+32];
	assign s_rd_rem   = s_rdata[2*LW+64:2*LW+33];
	assign s_rd_order = s_rdata[2*LW+96:2*LW+65];
	assign s_rd_user  = s_rdata[2*LW+128:2*LW+97];
	assign l_rd_tail  = l_rdata[LW-1:0];
	assign l_rd_head  = l_rdata[2*LW-1:LW];
	assign l_rd_total = l_rdata[2*LW+31:2*LW];
	assign l_rd_price = l_rdata[2*LW+63:2*LW+32];

	assign opp       = ~side_q;
	assign tq        = (rem_q < s_rd_rem) ? rem_q : s_rd_rem;
	assign s_rem_new = s_rd_rem - tq;
	assign cross_ok  = mkt_q || (!side_q ? (price_q >= l_rd_price) : (price_q <= l_rd_price));
	assign better    = !ws_q ? (f_price_q > l_rd_price) : (f_price_q < l_rd_price);
	assign t_present = cnt_q[t_q] != '0;
	assign t_cp      = t_present ? l_rd_price : 32'd0;
	assign t_cq      = t_present ? l_rd_total : 32'd0;
	assign t_diff    = (t_cp != prevp_q[t_q]) || (t_cq != prevq_q[t_q]);
	assign t_need    = t_diff && (t_present || ever_q[t_q]);

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q; ret_d = ret_q;
		cnt_d = cnt_q; valid_d = valid_q; prevp_d = prevp_q; prevq_d = prevq_q;
		ever_d = ever_q; ins_set_d = ins_set_q; f_found_d = f_found_q;
		free_found_d = free_found_q; c_found_d = c_found_q;
		user_d = user_q; oid_d = oid_q; price_d = price_q; rem_d = rem_q;
		side_d = side_q; mkt_d = mkt_q; ws_d = ws_q; t_d = t_q; f_price_d = f_price_q;
		i_d = i_q; ins_d = ins_q; lvpos_d = lvpos_q; j_d = j_q; s_d = s_q; p_d = p_q;
		la_d = la_q;
		cl_price_d = cl_price_q; cl_total_d = cl_total_q;
		cl_head_d = cl_head_q; cl_tail_d = cl_tail_q;
		sw_rem_d = sw_rem_q;
		sw_next_d = sw_next_q; sw_prev_d = sw_prev_q;
		s_re = 1'b0; s_raddr = '0; s_we = 1'b0; s_waddr = '0; s_wdata = '0;
		l_re = 1'b0; l_raddr = '0; l_we = 1'b0; l_waddr = '0; l_wdata = '0;
		req = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					user_d  = user_id;
					oid_d   = order_id;
					side_d  = side;
					mkt_d   = is_market;
					price_d = price;
					rem_d   = quantity;
					j_d     = '0;
					c_found_d = 1'b0;
					priority case (func)
						FUNC_NEW:    state_d = ST_ACK;
						FUNC_CANCEL: state_d = ST_C_RD;
						FUNC_FLUSH: begin
							cnt_d[0] = '0; cnt_d[1] = '0;
							valid_d = '0;
							prevp_d[0] = '0; prevp_d[1] = '0;
							prevq_d[0] = '0; prevq_d[1] = '0;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ACK: begin
				req.emit = 1'b1;
				req.msg.kind = MSG_ACK;
				req.msg.user1 = user_q;
				req.msg.order1 = oid_q;
				if (msg_ok) begin
					state_d = ST_M_CHK;
				end
			end
			ST_M_CHK: begin
				ws_d = opp;
				if (rem_q == '0 || cnt_q[opp] == '0) begin
					state_d = ST_REST;
				end else begin
					la_d = lvl_addr(opp, '0);
					l_re = 1'b1;
					l_raddr = lvl_addr(opp, '0);
					state_d = ST_M_LV;
				end
			end
			ST_M_LV: begin
				if (!cross_ok) begin
					state_d = ST_REST;
				end else begin
					cl_price_d = l_rd_price; cl_total_d = l_rd_total;
					cl_head_d = l_rd_head; cl_tail_d = l_rd_tail;
					p_d = l_rd_head;
					state_d = ST_M_SRD;
				end
			end
			ST_M_SRD: begin
				if (rem_q == '0 || p_q == NOSLOT) begin
					state_d = ST_M_LEND;
				end else begin
					s_re = 1'b1;
					s_raddr = p_q[SW-1:0];
					state_d = ST_M_TR;
				end
			end
			ST_M_TR: begin
				req.emit = 1'b1;
				req.msg.kind = MSG_TRADE;
				req.msg.user1  = side_q ? s_rd_user : user_q;
				req.msg.order1 = side_q ? s_rd_order : oid_q;
				req.msg.user2  = side_q ? user_q : s_rd_user;
				req.msg.order2 = side_q ? oid_q : s_rd_order;
				req.msg.price  = cl_price_q;
				req.msg.qty    = tq;
				if (msg_ok) begin
					rem_d = rem_q - tq;
					cl_total_d = cl_total_q - tq;
					s_we = 1'b1;
					s_waddr = p_q[SW-1:0];
					s_wdata = {s_rd_user, s_rd_order, s_rem_new, s_rd_side, s_rd_price,
						s_rd_next, s_rd_prev};
					sw_next_d = s_rd_next;
					sw_prev_d = s_rd_prev;
					p_d = s_rd_next;
					if (s_rem_new == '0) begin
						valid_d[p_q[SW-1:0]] = 1'b0;
						ret_d = ST_M_SRD;
						state_d = ST_U_START;
					end else begin
						state_d = ST_M_SRD;
					end
				end
			end
			ST_M_LEND: begin
				if (cl_head_q == NOSLOT) begin
					i_d = '0;
					ret_d = ST_M_CHK;
					state_d = ST_REM_RD;
				end else begin
					l_we = 1'b1;
					l_waddr = la_q;
					l_wdata = {cl_price_q, cl_total_q, cl_head_q, cl_tail_q};
					state_d = ST_M_CHK;
				end
			end
			ST_REST: begin
				if (rem_q == '0 || mkt_q) begin
					state_d = ST_T_INIT;
				end else begin
					ws_d = side_q;
					f_price_d = price_q;
					j_d = '0;
					state_d = ST_FREE;
				end
			end
			ST_FREE: begin
				if (!valid_q[j_q]) begin
					free_found_d = 1'b1;
					s_d = j_q;
					ret_d = ST_R_DEC;
					state_d = ST_F_INIT;
				end else if (j_q == SW'(S - 1)) begin
					free_found_d = 1'b0;
					ret_d = ST_R_DEC;
					state_d = ST_F_INIT;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			ST_F_INIT: begin
				i_d = '0;
				ins_d = cnt_q[ws_q];
				ins_set_d = 1'b0;
				f_found_d = 1'b0;
				state_d = ST_F_RD;
			end
			ST_F_RD: begin
				if (i_q < cnt_q[ws_q]) begin
					l_re = 1'b1;
					l_raddr = lvl_addr(ws_q, i_q);
					state_d = ST_F_CMP;
				end else begin
					state_d = ret_q;
				end
			end
			ST_F_CMP: begin
				if (l_rd_price == f_price_q) begin
					f_found_d = 1'b1;
					state_d = ret_q;
				end else begin
					if (!ins_set_q && better) begin
						ins_d = i_q;
						ins_set_d = 1'b1;
					end
					i_d = i_q + 1'b1;
					state_d = ST_F_RD;
				end
			end
			ST_R_DEC: begin
				if (!free_found_q || (!f_found_q && cnt_q[ws_q] >= PW'(L))) begin
					state_d = ST_REJ;
				end else if (f_found_q) begin
					la_d = lvl_addr(ws_q, i_q);
					state_d = ST_R_LRD;
				end else begin
					i_d = cnt_q[ws_q];
					state_d = ST_I_RD;
				end
			end
			ST_REJ: begin
				req.emit = 1'b1;
				req.msg.kind = MSG_REJECT;
				req.msg.user1 = user_q;
				req.msg.order1 = oid_q;
				req.msg.price = price_q;
				req.msg.qty = rem_q;
				req.msg.side = side_q;
				if (msg_ok) begin
					state_d = ST_T_INIT;
				end
			end
			ST_I_RD: begin
				if (i_q > ins_q) begin
					l_re = 1'b1;
					l_raddr = lvl_addr(ws_q, i_q - 1'b1);
					state_d = ST_I_W;
				end else begin
					cl_price_d = price_q;
					cl_total_d = '0;
					cl_head_d = NOSLOT;
					cl_tail_d = NOSLOT;
					la_d = lvl_addr(ws_q, ins_q);
					cnt_d[ws_q] = cnt_q[ws_q] + 1'b1;
					state_d = ST_R_APP;
				end
			end
			ST_I_W: begin
				l_we = 1'b1;
				l_waddr = lvl_addr(ws_q, i_q);
				l_wdata = l_rdata;
				i_d = i_q - 1'b1;
				state_d = ST_I_RD;
			end
			ST_R_LRD: begin
				l_re = 1'b1;
				l_raddr = la_q;
				state_d = ST_R_LLAT;
			end
			ST_R_LLAT: begin
				cl_price_d = l_rd_price; cl_total_d = l_rd_total;
				cl_head_d = l_rd_head; cl_tail_d = l_rd_tail;
				state_d = ST_R_APP;
			end
			ST_R_APP: begin
				s_we = 1'b1;
				s_waddr = s_q;
				s_wdata = {user_q, oid_q, rem_q, side_q, price_q, NOSLOT, cl_tail_q};
				valid_d[s_q] = 1'b1;
				if (cl_tail_q != NOSLOT) begin
					s_re = 1'b1;
					s_raddr = cl_tail_q[SW-1:0];
					state_d = ST_R_TRD;
				end else begin
					state_d = ST_R_LW;
				end
			end
			ST_R_TRD: begin
				s_we = 1'b1;
				s_waddr = cl_tail_q[SW-1:0];
				s_wdata = {s_rd_user, s_rd_order, s_rd_rem, s_rd_side, s_rd_price,
					LW'(s_q), s_rd_prev};
				state_d = ST_R_LW;
			end
			ST_R_LW: begin
				l_we = 1'b1;
				l_waddr = la_q;
				l_wdata = {cl_price_q, cl_total_q + rem_q,
					(cl_head_q == NOSLOT) ? LW'(s_q) : cl_head_q, LW'(s_q)};
				state_d = ST_T_INIT;
			end
			ST_T_INIT: begin
				t_d = 1'b0;
				state_d = ST_T_RD;
			end
			ST_T_RD: begin
				if (cnt_q[t_q] != '0) begin
					l_re = 1'b1;
					l_raddr = lvl_addr(t_q, '0);
				end
				state_d = ST_T_CMP;
			end
			ST_T_CMP: begin
				req.emit = t_need;
				req.msg.kind = t_present ? MSG_TOP : MSG_ELIM;
				req.msg.price = t_cp;
				req.msg.qty = t_cq;
				req.msg.side = t_q;
				if (!t_need || msg_ok) begin
					if (t_present) begin
						ever_d[t_q] = 1'b1;
					end
					if (t_diff) begin
						prevp_d[t_q] = t_cp;
						prevq_d[t_q] = t_cq;
					end
					if (!t_q) begin
						t_d = 1'b1;
						state_d = ST_T_RD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				req.fin = 1'b1;
				if (msg_ok) begin
					state_d = ST_IDLE;
				end
			end
			ST_C_RD: begin
				s_re = 1'b1;
				s_raddr = j_q;
				state_d = ST_C_CMP;
			end
			ST_C_CMP: begin
				if (valid_q[j_q] && s_rd_user == user_q && s_rd_order == oid_q) begin
					c_found_d = 1'b1;
					s_d = j_q;
					sw_rem_d = s_rd_rem;
					sw_next_d = s_rd_next; sw_prev_d = s_rd_prev;
					ws_d = s_rd_side;
					f_price_d = s_rd_price;
					ret_d = ST_C_LV;
					state_d = ST_F_INIT;
				end else if (j_q == SW'(S - 1)) begin
					state_d = ST_C_ACK;
				end else begin
					j_d = j_q + 1'b1;
					state_d = ST_C_RD;
				end
			end
			ST_C_LV: begin
				if (f_found_q) begin
					la_d = lvl_addr(ws_q, i_q);
					lvpos_d = i_q;
					l_re = 1'b1;
					l_raddr = lvl_addr(ws_q, i_q);
					state_d = ST_C_LLAT;
				end else begin
					valid_d[s_q] = 1'b0;
					state_d = ST_C_ACK;
				end
			end
			ST_C_LLAT: begin
				cl_price_d = l_rd_price;
				cl_total_d = l_rd_total - sw_rem_q;
				cl_head_d = l_rd_head;
				cl_tail_d = l_rd_tail;
				valid_d[s_q] = 1'b0;
				ret_d = ST_C_LW;
				state_d = ST_U_START;
			end
			ST_C_LW: begin
				if (cl_head_q == NOSLOT) begin
					i_d = lvpos_q;
					ret_d = ST_C_ACK;
					state_d = ST_REM_RD;
				end else begin
					l_we = 1'b1;
					l_waddr = la_q;
					l_wdata = {cl_price_q, cl_total_q, cl_head_q, cl_tail_q};
					state_d = ST_C_ACK;
				end
			end
			ST_C_ACK: begin
				req.emit = 1'b1;
				req.msg.kind = MSG_CANCEL_ACK;
				req.msg.user1 = user_q;
				req.msg.order1 = oid_q;
				if (msg_ok) begin
					state_d = c_found_q ? ST_T_INIT : ST_FIN;
				end
			end
			ST_U_START: begin
				if (sw_prev_q != NOSLOT) begin
					s_re = 1'b1;
					s_raddr = sw_prev_q[SW-1:0];
					state_d = ST_U_PW;
				end else begin
					cl_head_d = sw_next_q;
					state_d = ST_U_N;
				end
			end
			ST_U_PW: begin
				s_we = 1'b1;
				s_waddr = sw_prev_q[SW-1:0];
				s_wdata = {s_rd_user, s_rd_order, s_rd_rem, s_rd_side, s_rd_price,
					sw_next_q, s_rd_prev};
				state_d = ST_U_N;
			end
			ST_U_N: begin
				if (sw_next_q != NOSLOT) begin
					s_re = 1'b1;
					s_raddr = sw_next_q[SW-1:0];
					state_d = ST_U_NW;
				end else begin
					cl_tail_d = sw_prev_q;
					state_d = ret_q;
				end
			end
			ST_U_NW: begin
				s_we = 1'b1;
				s_waddr = sw_next_q[SW-1:0];
				s_wdata = {s_rd_user, s_rd_order, s_rd_rem, s_rd_side, s_rd_price,
					s_rd_next, sw_prev_q};
				state_d = ret_q;
			end
			ST_REM_RD: begin
				if ((PW + 1)'(i_q) + 1'b1 < (PW + 1)'(cnt_q[ws_q])) begin
					l_re = 1'b1;
					l_raddr = lvl_addr(ws_q, i_q + 1'b1);
					state_d = ST_REM_W;
				end else begin
					cnt_d[ws_q] = cnt_q[ws_q] - 1'b1;
					state_d = ret_q;
				end
			end
			ST_REM_W: begin
				l_we = 1'b1;
				l_waddr = lvl_addr(ws_q, i_q);
				l_wdata = l_rdata;
				i_d = i_q + 1'b1;
				state_d = ST_REM_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			cnt_q[0] <= '0; cnt_q[1] <= '0;
			valid_q <= '0;
			prevp_q[0] <= '0; prevp_q[1] <= '0;
			prevq_q[0] <= '0; prevq_q[1] <= '0;
			ever_q <= '0;
			ins_set_q <= 1'b0; f_found_q <= 1'b0;
			free_found_q <= 1'b0; c_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			cnt_q <= cnt_d;
			valid_q <= valid_d;
			prevp_q <= prevp_d;
			prevq_q <= prevq_d;
			ever_q <= ever_d;
			ins_set_q <= ins_set_d; f_found_q <= f_found_d;
			free_found_q <= free_found_d; c_found_q <= c_found_d;
		end
	end

	always_ff @(posedge clk) begin
		user_q <= user_d; oid_q <= oid_d; price_q <= price_d; rem_q <= rem_d;
		side_q <= side_d; mkt_q <= mkt_d; ws_q <= ws_d; t_q <= t_d;
		f_price_q <= f_price_d;
		i_q <= i_d; ins_q <= ins_d; lvpos_q <= lvpos_d;
		j_q <= j_d; s_q <= s_d; p_q <= p_d; la_q <= la_d;
		cl_price_q <= cl_price_d; cl_total_q <= cl_total_d;
		cl_head_q <= cl_head_d; cl_tail_q <= cl_tail_d;
		sw_rem_q <= sw_rem_d;
		sw_next_q <= sw_next_d; sw_prev_q <= sw_prev_d;
	end

	lobm_ram #(
		.DATA_W(SLW),
		.DEPTH (S)
	) u_slot_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.re   (s_re),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	lobm_ram #(
		.DATA_W(LVW),
		.DEPTH (2 * L)
	) u_level_ram (
		.clk  (clk),
		.we   (l_we),
		.waddr(l_waddr),
		.wdata(l_wdata),
		.re   (l_re),
		.raddr(l_raddr),
		.rdata(l_rdata)
	);

	lobm_msg_out u_msg_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.ok          (msg_ok),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.msg_kind    (msg_kind),
		.first_user  (first_user),
		.first_order (first_order),
		.second_user (second_user),
		.second_order(second_order),
		.out_price   (out_price),
		.out_quantity(out_quantity),
		.out_side    (out_side),
		.last        (last)
	);
endmodule
`default_nettype wire

FILE: tb/lobm_checker.sv
`timescale 1ns / 1ps
module lobm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] user_id,
	input  logic [31:0] order_id,
	input  logic        side,
	input  logic        is_market,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  msg_kind,
	input  logic [31:0] first_user,
	input  logic [31:0] first_order,
	input  logic [31:0] second_user,
	input  logic [31:0] second_order,
	input  logic [31:0] out_price,
	input  logic [31:0] out_quantity,
	input  logic        out_side,
	input  logic        last,
	output int          errors,
	output int          pending
);
	import lobm_pkg::*;

	localparam int NS = ORDER_SLOTS_DEF;
	localparam int NL = LEVELS_DEF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] u1;
		logic [31:0] o1;
		logic [31:0] u2;
		logic [31:0] o2;
		logic [31:0] p;
		logic [31:0] q;
		logic        sd;
		logic        fin;
	} book_msg_t;

	book_msg_t msg_fifo[$];
	int first_new;

	logic [31:0] lv_price[2][NL];
	logic [31:0] lv_total[2][NL];
	int          lv_head[2][NL];
	int          lv_tail[2][NL];
	int          lv_cnt[2];
	bit          sl_valid[NS];
	logic [31:0] sl_user[NS];
	logic [31:0] sl_order[NS];
	logic [31:0] sl_rem[NS];
	bit          sl_side[NS];
	logic [31:0] sl_price[NS];
	int          sl_next[NS];
	int          sl_prev[NS];
	logic [31:0] top_p[2];
	logic [31:0] top_q[2];
	bit          ever[2];

	assign pending = msg_fifo.size();

	task automatic post(input logic [2:0] k, input logic [31:0] u1, o1, u2, o2, p, q,
			input logic sd);
		book_msg_t m;
		m = '{k, u1, o1, u2, o2, p, q, sd, 1'b0};
		msg_fifo.push_back(m);
	endtask

	task automatic unlink(input int sd, input int lv, input int s);
		int pv, nx;
		pv = sl_prev[s];
		nx = sl_next[s];
		if (pv < NS) sl_next[pv] = nx; else lv_head[sd][lv] = nx;
		if (nx < NS) sl_prev[nx] = pv; else lv_tail[sd][lv] = pv;
		sl_valid[s] = 0;
	endtask

	task automatic drop_level(input int sd, input int pos);
		for (int i = pos; i + 1 < lv_cnt[sd]; i++) begin
			lv_price[sd][i] = lv_price[sd][i+1];
			lv_total[sd][i] = lv_total[sd][i+1];
			lv_head[sd][i]  = lv_head[sd][i+1];
			lv_tail[sd][i]  = lv_tail[sd][i+1];
		end
		lv_cnt[sd]--;
	endtask

	function automatic int level_of(input int sd, input logic [31:0] p);
		for (int i = 0; i < lv_cnt[sd]; i++)
			if (lv_price[sd][i] == p) return i;
		return -1;
	endfunction

	task automatic top_check();
		logic [31:0] cp, cq;
		for (int sd = 0; sd < 2; sd++) begin
			cp = 0;
			cq = 0;
			if (lv_cnt[sd] > 0) begin
				cp = lv_price[sd][0];
				cq = lv_total[sd][0];
				ever[sd] = 1;
			end
			if (cp != top_p[sd] || cq != top_q[sd]) begin
				if (lv_cnt[sd] > 0) post(MSG_TOP, 0, 0, 0, 0, cp, cq, sd[0]);
				else if (ever[sd]) post(MSG_ELIM, 0, 0, 0, 0, 0, 0, sd[0]);
				top_p[sd] = cp;
				top_q[sd] = cq;
			end
		end
	endtask

	task automatic new_order(input logic sd, mkt, input logic [31:0] u, o, p, qty);
		int opp, s, nx, lvi, pos;
		logic [31:0] rem, lp, tq;
		bit can;
		rem = qty;
		opp = !sd;
		post(MSG_ACK, u, o, 0, 0, 0, 0, 0);
		while (rem > 0 && lv_cnt[opp] > 0) begin
			lp = lv_price[opp][0];
			can = mkt || (sd == 0 ? p >= lp : p <= lp);
			if (!can) break;
			s = lv_head[opp][0];
			while (rem > 0 && s < NS) begin
				nx = sl_next[s];
				tq = rem < sl_rem[s] ? rem : sl_rem[s];
				if (sd == 0) post(MSG_TRADE, u, o, sl_user[s], sl_order[s], lp, tq, 0);
				else post(MSG_TRADE, sl_user[s], sl_order[s], u, o, lp, tq, 0);
				rem -= tq;
				sl_rem[s] -= tq;
				lv_total[opp][0] -= tq;
				if (sl_rem[s] == 0) unlink(opp, 0, s);
				s = nx;
			end
			if (lv_head[opp][0] >= NS) drop_level(opp, 0);
		end
		if (rem > 0 && !mkt) begin
			lvi = level_of(sd, p);
			for (s = 0; s < NS; s++) if (!sl_valid[s]) break;
			if (s >= NS || (lvi < 0 && lv_cnt[sd] >= NL)) begin
				post(MSG_REJECT, u, o, 0, 0, p, rem, sd);
			end else begin
				if (lvi < 0) begin
					pos = lv_cnt[sd];
					for (int i = 0; i < lv_cnt[sd]; i++)
						if (sd == 0 ? p > lv_price[sd][i] : p < lv_price[sd][i]) begin
							pos = i;
							break;
						end
					for (int i = lv_cnt[sd]; i > pos; i--) begin
						lv_price[sd][i] = lv_price[sd][i-1];
						lv_total[sd][i] = lv_total[sd][i-1];
						lv_head[sd][i]  = lv_head[sd][i-1];
						lv_tail[sd][i]  = lv_tail[sd][i-1];
					end
					lv_price[sd][pos] = p;
					lv_total[sd][pos] = 0;
					lv_head[sd][pos] = NS;
					lv_tail[sd][pos] = NS;
					lv_cnt[sd]++;
					lvi = pos;
				end
				sl_valid[s] = 1;
				sl_user[s] = u;
				sl_order[s] = o;
				sl_rem[s] = rem;
				sl_side[s] = sd;
				sl_price[s] = p;
				sl_next[s] = NS;
				sl_prev[s] = lv_tail[sd][lvi];
				if (lv_tail[sd][lvi] < NS) sl_next[lv_tail[sd][lvi]] = s;
				else lv_head[sd][lvi] = s;
				lv_tail[sd][lvi] = s;
				lv_total[sd][lvi] += rem;
			end
		end
		top_check();
	endtask

	task automatic cancel_order(input logic [31:0] u, o);
		int s, sd, lvi;
		for (s = 0; s < NS; s++)
			if (sl_valid[s] && sl_user[s] == u && sl_order[s] == o) break;
		post(MSG_CANCEL_ACK, u, o, 0, 0, 0, 0, 0);
		if (s < NS) begin
			sd = sl_side[s];
			lvi = level_of(sd, sl_price[s]);
			if (lvi >= 0) begin
				lv_total[sd][lvi] -= sl_rem[s];
				unlink(sd, lvi, s);
				if (lv_head[sd][lvi] >= NS) drop_level(sd, lvi);
			end
			sl_valid[s] = 0;
			top_check();
		end
	endtask

	task automatic report(input string what, input logic [31:0] got, want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		book_msg_t w;
		if (!arst_n) begin
			msg_fifo.delete();
			lv_cnt = '{0, 0};
			top_p = '{0, 0};
			top_q = '{0, 0};
			ever = '{0, 0};
			foreach (sl_valid[i]) sl_valid[i] = 0;
		end else begin
			if (in_valid && !in_stall) begin
				first_new = msg_fifo.size();
				case (func)
					FUNC_NEW: new_order(side, is_market, user_id, order_id, price, quantity);
					FUNC_CANCEL: cancel_order(user_id, order_id);
					FUNC_FLUSH: begin
						lv_cnt = '{0, 0};
						foreach (sl_valid[i]) sl_valid[i] = 0;
						top_p = '{0, 0};
						top_q = '{0, 0};
					end
					default: ;
				endcase
				if (msg_fifo.size() > first_new) msg_fifo[msg_fifo.size()-1].fin = 1;
			end
			if (out_valid && !out_stall) begin
				if (msg_fifo.size() == 0) begin
					report("unexpected transfer kind", msg_kind, 0);
				end else begin
					w = msg_fifo.pop_front();
					if (msg_kind != w.kind) report("msg_kind", msg_kind, w.kind);
					if (first_user != w.u1) report("first_user", first_user, w.u1);
					if (first_order != w.o1) report("first_order", first_order, w.o1);
					if (second_user != w.u2) report("second_user", second_user, w.u2);
					if (second_order != w.o2) report("second_order", second_order, w.o2);
					if (out_price != w.p) report("out_price", out_price, w.p);
					if (out_quantity != w.q) report("out_quantity", out_quantity, w.q);
					if (out_side != w.sd) report("out_side", out_side, w.sd);
					if (last != w.fin) report("last", last, w.fin);
				end
			end
		end
	end
endmodule

FILE: tb/tb_limit_order_book_matcher_top.sv
`timescale 1ns / 1ps
module tb_limit_order_book_matcher_top;
	import lobm_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [31:0] user_id, order_id, price, quantity;
	logic        side, is_market;
	logic        out_valid, out_stall;
	logic [2:0]  msg_kind;
	logic [31:0] first_user, first_order, second_user, second_order, out_price, out_quantity;
	logic        out_side, last;
	int          errors, pending;
	int          cycles;
	bit          hold_rx;

	logic [31:0] live_user[$];
	logic [31:0] live_order[$];

	limit_order_book_matcher_top dut (.*);

	lobm_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 5000000) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int g;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) out_stall = 1;
			else begin
				g = gap_len();
				if (g > 0 && $urandom_range(0, 3) == 0) begin
					out_stall = 1;
					repeat (g) @(negedge clk);
				end
				out_stall = hold_rx;
			end
		end
	end

	task automatic send(input logic [1:0] f, input logic [31:0] u, o, input logic sd, mk,
			input logic [31:0] p, q);
		func = f;
		user_id = u;
		order_id = o;
		side = sd;
		is_market = mk;
		price = p;
		quantity = q;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
		if (f == FUNC_NEW && !mk && live_user.size() < 200) begin
			live_user.push_back(u);
			live_order.push_back(o);
		end
	endtask

	task automatic rand_item();
		int r, k;
		logic [31:0] u, o;
		r = $urandom_range(0, 99);
		u = $urandom_range(1, 4);
		o = $urandom_range(0, 40);
		if (r < 3) begin
			send(FUNC_FLUSH, $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom,
				$urandom);
		end else if (r < 5) begin
			send(FUNC_UNUSED, $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom,
				$urandom);
		end else if (r < 25 && live_user.size() > 0) begin
			k = $urandom_range(0, live_user.size() - 1);
			send(FUNC_CANCEL, live_user[k], live_order[k], 1'($urandom), 1'($urandom), 0, 0);
		end else if (r < 28) begin
			send(FUNC_CANCEL, $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom,
				$urandom);
		end else if (r < 33) begin
			send(FUNC_NEW, $urandom, $urandom, 1'($urandom), 1'($urandom), $urandom,
				$urandom);
		end else begin
			send(FUNC_NEW, u, o, 1'($urandom), $urandom_range(0, 9) == 0,
				$urandom_range(90, 110), $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 50));
		end
	endtask

	initial begin
		in_valid = 0;
		func = FUNC_NEW;
		user_id = 0;
		order_id = 0;
		side = 0;
		is_market = 0;
		price = 0;
		quantity = 0;
		hold_rx = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(FUNC_NEW, 1, 1, 0, 0, 100, 10);
		send(FUNC_NEW, 2, 2, 0, 0, 100, 5);
		send(FUNC_NEW, 3, 3, 1, 0, 0, 3);
		send(FUNC_NEW, 4, 4, 1, 0, 105, 7);
		send(FUNC_NEW, 5, 5, 1, 1, 0, 20);
		send(FUNC_NEW, 6, 6, 0, 1, 32'hffffffff, 100);
		send(FUNC_NEW, 7, 7, 0, 0, 50, 0);
		send(FUNC_NEW, 32'hffffffff, 32'hffffffff, 1, 0, 32'hffffffff, 32'hffffffff);
		send(FUNC_NEW, 32'hffffffff, 32'hffffffff, 1, 0, 32'hffffffff, 32'h10);
		send(FUNC_CANCEL, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0);
		send(FUNC_CANCEL, 9, 9, 0, 0, 0, 0);
		send(FUNC_NEW, 8, 8, 0, 0, 0, 1);
		send(FUNC_NEW, 8, 9, 1, 0, 0, 1);
		send(FUNC_UNUSED, 1, 1, 1, 1, 1, 1);
		send(FUNC_FLUSH, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 18; i++) send(FUNC_NEW, 10, i, 1, 0, 200 + i, 1);
		for (int i = 0; i < 16; i++) send(FUNC_NEW, 11, i, 1, 0, 200, 1);
		send(FUNC_NEW, 12, 0, 0, 1, 0, 32'hffffffff);
		send(FUNC_FLUSH, 0, 0, 0, 0, 0, 0);

		fork
			begin
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < 20; i++) rand_item();
		join

		for (int i = 0; i < 350; i++) begin
			if (i == 175) while (pending != 0) @(negedge clk);
			rand_item();
			repeat (gap_len()) @(negedge clk);
		end
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
